/* hdl/crst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_pkg
// shared constants, item codes and saturation helper for the spline table
// ----------------------------------------------------------------------------
package crst_pkg;

  localparam int unsigned MaxNodesDef = 256;
  localparam int unsigned FracBitsDef = 16;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ParamTW   = 24;
  localparam int unsigned CountOutW = 9;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 128;
  localparam int unsigned OutDataW  = 208;
  // horner accumulator, wide enough for every intermediate term
  localparam int unsigned HornW     = 38;

  localparam logic [KindW-1:0] KIND_APPEND = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KindW-1:0] KIND_UPDATE = 3'd2;
  localparam logic [KindW-1:0] KIND_EVAL   = 3'd3;
  localparam logic [KindW-1:0] KIND_READ   = 3'd4;

  localparam logic [StatusW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatusW-1:0] STAT_IGNORED = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL    = 2'd2;
  localparam logic [StatusW-1:0] STAT_RANGE   = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  function automatic coord_t sat_coord(input logic signed [HornW-1:0] v);
    logic signed [HornW-1:0] hi;
    logic signed [HornW-1:0] lo;
    hi = $signed({{(HornW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

/* hdl/catmull_rom_spline_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_table_unit
// table of 3d control points with tangents, cubic hermite evaluation
// ----------------------------------------------------------------------------
// channel  dir  data                                    user
// s_axis   in   index, in_x, in_y, in_z, param_t       kind
// m_axis   out  out_x..z, tan_x..z, node_count          status
//
// one transaction in, one out; a new item is taken once the previous is done
// read node passes an address and a capture state; zero-fraction evaluate
// reads the point and finishes; failures go straight to the finish state
// append and update write the point, then refresh up to three tangents,
// skipping neighbours outside the table; insert first shifts entries up;
// evaluate uses the one shared multiplier for three horner steps on each axis
// the finish state holds while the output register still holds a transaction
// reset clears the node count, state and output valid; table contents need no clearing
// ----------------------------------------------------------------------------
module catmull_rom_spline_table_unit #(
  parameter int unsigned MAX_NODES = crst_pkg::MaxNodesDef,
  parameter int unsigned FRAC_BITS = crst_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // index, in_x, in_y, in_z, param_t
  input  logic [crst_pkg::InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [crst_pkg::KindW-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_z, tan_x, tan_y, tan_z, node_count
  output logic [crst_pkg::OutDataW-1:0] m_axis_tdata,
  // status
  output logic [crst_pkg::StatusW-1:0]  m_axis_tuser
);

  localparam int unsigned AW   = $clog2(MAX_NODES);
  localparam int unsigned CW   = $clog2(MAX_NODES + 1);
  localparam int unsigned CTRW = CW + 1;
  localparam int unsigned SEGW = crst_pkg::ParamTW - FRAC_BITS;
  localparam int unsigned HW   = crst_pkg::HornW;
  localparam int unsigned PW   = HW + FRAC_BITS + 1;
  localparam int unsigned MW   = 3 * crst_pkg::CoordW;
  localparam int unsigned DW   = crst_pkg::CoordW + 1;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'b00000000000000001,
    ST_SH_RD   = 17'b00000000000000010,
    ST_SH_WR   = 17'b00000000000000100,
    ST_PT_WR   = 17'b00000000000001000,
    ST_REF_CHK = 17'b00000000000010000,
    ST_REF_LO  = 17'b00000000000100000,
    ST_REF_HI  = 17'b00000000001000000,
    ST_REF_WR  = 17'b00000000010000000,
    ST_EV_RD0  = 17'b00000000100000000,
    ST_EV_RD1  = 17'b00000001000000000,
    ST_EV_CAP  = 17'b00000010000000000,
    ST_EV_COEF = 17'b00000100000000000,
    ST_EV_MUL  = 17'b00001000000000000,
    ST_EV_ACC  = 17'b00010000000000000,
    ST_RD_ADDR = 17'b00100000000000000,
    ST_RD_CAP  = 17'b01000000000000000,
    ST_FINISH  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 wr_addr_q;
  logic [CW-1:0]                 j_q;
  logic                          inc_q;
  logic signed [CTRW-1:0]        ctr_q, ctr_end_q;
  logic                          before_q, after_q;
  logic [AW-1:0]                 rd_addr_q;
  logic                          zero_frac_q;
  logic [FRAC_BITS-1:0]          s_q;
  crst_pkg::coord_t              pin_q [3];
  crst_pkg::coord_t              lo_q  [3];
  crst_pkg::coord_t              p0_q  [3];
  crst_pkg::coord_t              p1_q  [3];
  crst_pkg::coord_t              m0_q  [3];
  crst_pkg::coord_t              m1_q  [3];
  crst_pkg::coord_t              res_q [6];
  logic [crst_pkg::StatusW-1:0]  stat_q;
  logic [1:0]                    axis_q, step_q;
  logic signed [HW-1:0]          h_q, b_q;
  logic signed [PW-1:0]          prod_q;

  logic                          m_valid_q;
  logic [crst_pkg::OutDataW-1:0] m_data_q;
  logic [crst_pkg::StatusW-1:0]  m_user_q;

  // input fields
  logic [crst_pkg::KindW-1:0]    in_kind;
  logic [crst_pkg::IndexW-1:0]   in_idx;
  logic [crst_pkg::ParamTW-1:0]  in_t;
  logic [SEGW-1:0]               in_seg;
  logic [FRAC_BITS-1:0]          in_frac;
  logic                          accept;
  logic                          idx_ge, is_full;
  logic [crst_pkg::StatusW-1:0]  in_stat;

  assign in_kind = s_axis_tuser;
  assign in_idx  = s_axis_tdata[7:0];
  assign in_t    = s_axis_tdata[127:104];
  assign in_seg  = in_t[crst_pkg::ParamTW-1:FRAC_BITS];
  assign in_frac = in_t[FRAC_BITS-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign idx_ge  = 32'(in_idx) >= 32'(count_q);
  assign is_full = 32'(count_q) >= 32'(MAX_NODES);

  // status of the incoming item
  always_comb begin
    in_stat = crst_pkg::STAT_OK;
    unique case (in_kind) inside
      crst_pkg::KIND_APPEND, crst_pkg::KIND_INSERT: begin
        if (is_full) in_stat = crst_pkg::STAT_FULL;
      end
      crst_pkg::KIND_UPDATE, crst_pkg::KIND_READ: begin
        if (idx_ge) in_stat = crst_pkg::STAT_IGNORED;
      end
      crst_pkg::KIND_EVAL: begin
        if (32'(count_q) >= 32'd2) begin
          if (in_frac == '0) begin
            if (32'(in_seg) >= 32'(count_q)) in_stat = crst_pkg::STAT_RANGE;
          end else if (32'(in_seg) + 32'd1 >= 32'(count_q)) begin
            in_stat = crst_pkg::STAT_RANGE;
          end
        end
      end
      default: in_stat = crst_pkg::STAT_IGNORED;
    endcase
  end

  // memories: {z, y, x}
  logic            pwe, swe;
  logic [AW-1:0]   pwa, swa, ra;
  logic [MW-1:0]   pwd, swd, prd, srd;

  crst_ram #(.Width(MW), .Depth(MAX_NODES)) u_point_ram (
    .clk_i  (clk_i),
    .we_i   (pwe),
    .waddr_i(pwa),
    .wdata_i(pwd),
    .raddr_i(ra),
    .rdata_o(prd)
  );

  crst_ram #(.Width(MW), .Depth(MAX_NODES)) u_slope_ram (
    .clk_i  (clk_i),
    .we_i   (swe),
    .waddr_i(swa),
    .wdata_i(swd),
    .raddr_i(ra),
    .rdata_o(srd)
  );

  // tangent of the refreshed centre, hi data arriving from the point ram
  logic [MW-1:0] tan_word;
  always_comb begin
    logic signed [DW-1:0] d;
    tan_word = '0;
    for (int a = 0; a < 3; a++) begin
      d = DW'($signed(prd[32*a +: 32])) - DW'(lo_q[a]);
      if (before_q && after_q) begin
        tan_word[32*a +: 32] = d[DW-1:1];
      end else begin
        tan_word[32*a +: 32] = crst_pkg::sat_coord(HW'(d));
      end
    end
  end

  // horner datapath for the current axis
  logic signed [HW-1:0] p0a, p1a, m0a, m1a, coef_a, coef_b, addend, h_new;
  logic signed [PW-1:0] rnd_full, rnd_sh, prod_d;

  always_comb begin
    p0a = HW'(p0_q[axis_q]);
    p1a = HW'(p1_q[axis_q]);
    m0a = HW'(m0_q[axis_q]);
    m1a = HW'(m1_q[axis_q]);
    coef_a = (p0a <<< 1) + m0a - (p1a <<< 1) + m1a;
    coef_b = (p1a <<< 1) + p1a - (p0a <<< 1) - p0a - (m0a <<< 1) - m1a;
    case (step_q)
      2'd0:    addend = b_q;
      2'd1:    addend = m0a;
      default: addend = p0a;
    endcase
    prod_d   = PW'(h_q) * PW'($signed({1'b0, s_q}));
    rnd_full = prod_q + (PW'(1) <<< (FRAC_BITS - 1));
    rnd_sh   = rnd_full >>> FRAC_BITS;
    h_new    = HW'(rnd_sh) + addend;
  end

  // memory port control
  logic signed [CTRW-1:0] lo_idx, hi_idx;
  assign lo_idx = before_q ? ctr_q - CTRW'(1) : ctr_q;
  assign hi_idx = after_q  ? ctr_q + CTRW'(1) : ctr_q;

  always_comb begin
    pwe = 1'b0;
    swe = 1'b0;
    pwa = AW'(wr_addr_q);
    swa = AW'(ctr_q);
    pwd = {pin_q[2], pin_q[1], pin_q[0]};
    swd = tan_word;
    ra  = rd_addr_q;
    unique case (state_q)
      ST_SH_RD:  ra = AW'(j_q - CW'(1));
      ST_SH_WR: begin
        pwe = 1'b1;
        swe = 1'b1;
        pwa = AW'(j_q);
        swa = AW'(j_q);
        pwd = prd;
        swd = srd;
      end
      ST_PT_WR:  pwe = 1'b1;
      ST_REF_LO: ra = AW'(lo_idx);
      ST_REF_HI: ra = AW'(hi_idx);
      ST_REF_WR: swe = 1'b1;
      ST_EV_RD1: ra = rd_addr_q + AW'(1);
      default:   ra = rd_addr_q;
    endcase
  end

  // sequencer
  logic ctr_in_range;
  assign ctr_in_range = (ctr_q >= 0) && (ctr_q < $signed({1'b0, count_q}));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FINISH;
          unique case (in_kind) inside
            crst_pkg::KIND_APPEND, crst_pkg::KIND_INSERT: begin
              if (!is_full) begin
                state_d = (in_kind == crst_pkg::KIND_INSERT && !idx_ge) ? ST_SH_RD
                                                                         : ST_PT_WR;
              end
            end
            crst_pkg::KIND_UPDATE: if (!idx_ge) state_d = ST_PT_WR;
            crst_pkg::KIND_EVAL: begin
              if (32'(count_q) >= 32'd2) begin
                if (in_frac == '0) begin
                  if (32'(in_seg) < 32'(count_q)) state_d = ST_EV_RD0;
                end else if (32'(in_seg) + 32'd1 < 32'(count_q)) begin
                  state_d = ST_EV_RD0;
                end
              end
            end
            crst_pkg::KIND_READ: if (!idx_ge) state_d = ST_RD_ADDR;
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_SH_RD:  state_d = ST_SH_WR;
      ST_SH_WR:  state_d = (j_q - CW'(1) > wr_addr_q) ? ST_SH_RD : ST_PT_WR;
      ST_PT_WR:  state_d = ST_REF_CHK;
      ST_REF_CHK: begin
        if (ctr_in_range) state_d = ST_REF_LO;
        else if (ctr_q == ctr_end_q) state_d = ST_FINISH;
      end
      ST_REF_LO: state_d = ST_REF_HI;
      ST_REF_HI: state_d = ST_REF_WR;
      ST_REF_WR: state_d = (ctr_q == ctr_end_q) ? ST_FINISH : ST_REF_CHK;
      ST_EV_RD0: state_d = ST_EV_RD1;
      ST_EV_RD1: state_d = zero_frac_q ? ST_FINISH : ST_EV_CAP;
      ST_EV_CAP: state_d = ST_EV_COEF;
      ST_EV_COEF: state_d = ST_EV_MUL;
      ST_EV_MUL: state_d = ST_EV_ACC;
      ST_EV_ACC: begin
        if (step_q != 2'd2) state_d = ST_EV_MUL;
        else if (axis_q == 2'd2) state_d = ST_FINISH;
        else state_d = ST_EV_COEF;
      end
      ST_RD_ADDR: state_d = ST_RD_CAP;
      ST_RD_CAP:  state_d = ST_FINISH;
      ST_FINISH:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PT_WR && inc_q) begin
        count_q <= count_q + CW'(1);
      end
      if (state_q == ST_FINISH && state_d == ST_IDLE) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          for (int k = 0; k < 6; k++) res_q[k] <= '0;
          pin_q[0]    <= s_axis_tdata[39:8];
          pin_q[1]    <= s_axis_tdata[71:40];
          pin_q[2]    <= s_axis_tdata[103:72];
          s_q         <= in_frac;
          zero_frac_q <= (in_frac == '0);
          j_q         <= count_q;
          stat_q      <= in_stat;
          if (in_kind == crst_pkg::KIND_EVAL) begin
            rd_addr_q <= AW'(in_seg);
          end else begin
            rd_addr_q <= AW'(in_idx);
          end
          if (in_kind == crst_pkg::KIND_APPEND ||
              (in_kind == crst_pkg::KIND_INSERT && idx_ge)) begin
            wr_addr_q <= count_q;
            ctr_q     <= $signed({1'b0, count_q}) - CTRW'(1);
            ctr_end_q <= $signed({1'b0, count_q}) + CTRW'(1);
          end else begin
            wr_addr_q <= CW'(in_idx);
            ctr_q     <= $signed(CTRW'(in_idx)) - CTRW'(1);
            ctr_end_q <= $signed(CTRW'(in_idx)) + CTRW'(1);
          end
          inc_q <= (in_kind != crst_pkg::KIND_UPDATE);
        end
      end
      ST_SH_WR: j_q <= j_q - CW'(1);
      ST_REF_CHK: begin
        if (ctr_in_range) begin
          before_q <= ctr_q > 0;
          after_q  <= (ctr_q + CTRW'(1)) < $signed({1'b0, count_q});
        end else if (ctr_q != ctr_end_q) begin
          ctr_q <= ctr_q + CTRW'(1);
        end
      end
      ST_REF_HI: begin
        for (int a = 0; a < 3; a++) lo_q[a] <= prd[32*a +: 32];
      end
      ST_REF_WR: if (ctr_q != ctr_end_q) ctr_q <= ctr_q + CTRW'(1);
      ST_EV_RD1: begin
        for (int a = 0; a < 3; a++) begin
          p0_q[a] <= prd[32*a +: 32];
          m0_q[a] <= srd[32*a +: 32];
          if (zero_frac_q) res_q[a] <= prd[32*a +: 32];
        end
      end
      ST_EV_CAP: begin
        for (int a = 0; a < 3; a++) begin
          p1_q[a] <= prd[32*a +: 32];
          m1_q[a] <= srd[32*a +: 32];
        end
        axis_q <= 2'd0;
      end
      ST_EV_COEF: begin
        h_q    <= coef_a;
        b_q    <= coef_b;
        step_q <= 2'd0;
      end
      ST_EV_MUL: prod_q <= prod_d;
      ST_EV_ACC: begin
        h_q <= h_new;
        if (step_q == 2'd2) begin
          res_q[axis_q] <= crst_pkg::sat_coord(h_new);
          axis_q        <= axis_q + 2'd1;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
      ST_RD_CAP: begin
        for (int a = 0; a < 3; a++) begin
          res_q[a]     <= prd[32*a +: 32];
          res_q[a + 3] <= srd[32*a +: 32];
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {7'b0, crst_pkg::CountOutW'(count_q), res_q[5], res_q[4], res_q[3],
                       res_q[2], res_q[1], res_q[0]};
          m_user_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // count moves only when a point is written
  a_count_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == ST_PT_WR))
    else $error("node count changed outside point write");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_NODES))
    else $error("node count above table size");

  a_ref_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REF_WR) |-> ((ctr_q >= 0) && (ctr_q < $signed({1'b0, count_q}))))
    else $error("tangent write outside table");

  a_shift_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SH_RD) |-> (j_q > wr_addr_q))
    else $error("shift pointer at or below insert point");

endmodule

/* hdl/crst_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module crst_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
